// ===== design/energy_voice_activity_detector_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the energy voice activity detector
// Clocked assertion helpers that compile to nothing when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ENERGY_VOICE_ACTIVITY_DETECTOR_UNIT_MACROS_SVH
`define ENERGY_VOICE_ACTIVITY_DETECTOR_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define EVAD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define EVAD_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define EVAD_ASSERT(lbl, prop, msg)
`define EVAD_NEVER(lbl, expr, msg)
`endif
`endif

// ===== design/evad_pkg.sv =====
// ----------------------------------------------------------------------------
// Energy voice activity detector package
// Widths, register map, result codes and the threshold factor table.
// ----------------------------------------------------------------------------
package evad_pkg;

	localparam int MAX_FRAME = 1024;
	localparam int CNT_W     = $clog2(MAX_FRAME + 1);
	localparam int SAMPLE_W  = 16;
	localparam int SQ_W      = 2 * SAMPLE_W - 1;
	localparam int SUM_W     = SQ_W + CNT_W - 1;

	// Threshold factor: ceil(2^(30+K_FRAC) * 10^(-n/10)) for n = 0 .. THR_SPAN.
	localparam int K_FRAC    = 40;
	localparam int K_W       = 31 + K_FRAC;
	localparam int K_EXP     = 10 * (30 + K_FRAC);
	localparam int KLO_W     = 36;
	localparam int KHI_W     = K_W - KLO_W;
	localparam int CMP_W     = K_W + CNT_W;
	localparam int THR_SPAN  = 100;
	localparam int BIG_W     = 1040;

	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;
	localparam int THR_W     = 8;
	localparam int TIME_W    = 16;
	localparam int FMS_W     = 10;

	localparam logic [1:0] REG_THRESHOLD   = 2'd0;
	localparam logic [1:0] REG_MIN_SPEECH  = 2'd1;
	localparam logic [1:0] REG_MIN_SILENCE = 2'd2;
	localparam logic [1:0] REG_FRAME_MS    = 2'd3;

	localparam logic [1:0] RES_SILENCE = 2'd0;
	localparam logic [1:0] RES_SPEECH  = 2'd1;
	localparam logic [1:0] RES_END     = 2'd2;

	localparam int                       THR_RESET_N     = 40;
	localparam logic signed [THR_W-1:0]  THR_RESET       = THR_W'(-THR_RESET_N);
	localparam logic signed [THR_W-1:0]  THR_MIN         = -8'sd100;
	localparam logic [TIME_W-1:0]        MIN_SPEECH_RST  = 16'd100;
	localparam logic [TIME_W-1:0]        MIN_SILENCE_RST = 16'd500;
	localparam logic [FMS_W-1:0]         FRAME_MS_RST    = 10'd20;

	typedef logic [K_W-1:0] ktab_t [0:THR_SPAN];

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
	} frame_t;

	function automatic ktab_t build_ktab();
		ktab_t          tab;
		logic [BIG_W-1:0] p10;
		logic [BIG_W-1:0] target;
		logic [BIG_W-1:0] acc;
		logic [K_W:0]     lo;
		logic [K_W:0]     hi;
		logic [K_W:0]     mid;
		int               n;
		int               i;
		int               j;
		p10    = BIG_W'(1);
		target = BIG_W'(1) << K_EXP;
		for (n = 0; n <= THR_SPAN; n++) begin
			lo = '0;
			hi = (K_W + 1)'(1) << (K_W - 1);
			for (i = 0; i < K_W; i++) begin
				mid = (lo + hi) >> 1;
				acc = BIG_W'(1);
				for (j = 0; j < 10; j++) begin
					acc = acc * BIG_W'(mid);
				end
				if (acc * p10 >= target) begin
					hi = mid;
				end else begin
					lo = mid;
				end
			end
			tab[n] = hi[K_W-1:0];
			p10    = p10 * BIG_W'(10);
		end
		return tab;
	endfunction

	localparam ktab_t KTAB = build_ktab();

endpackage

// ===== design/evad_accum.sv =====
// ----------------------------------------------------------------------------
// Frame energy accumulator
// Registers each sample, squares it and sums squares and counts per frame.
// ----------------------------------------------------------------------------
module evad_accum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [evad_pkg::SAMPLE_W-1:0] sample,
	input  logic                          frame_end,
	output logic                          frm_valid,
	input  logic                          frm_ready,
	output evad_pkg::frame_t              frm
);

	logic                                  v_s1;
	logic signed [evad_pkg::SAMPLE_W-1:0]  sample_s1;
	logic                                  fe_s1;
	logic                                  v_s2;
	logic [evad_pkg::SQ_W-1:0]             sq_s2;
	logic                                  fe_s2;
	logic [evad_pkg::SUM_W-1:0]            acc_q;
	logic [evad_pkg::CNT_W-1:0]            cnt_q;
	logic                                  fv_s3;
	evad_pkg::frame_t                      frm_s3;

	logic                                  rdy1;
	logic                                  rdy2;
	logic                                  rdy3;
	logic                                  take2;
	logic signed [2*evad_pkg::SAMPLE_W-1:0] sq_full;
	logic                                  cnt_ok;
	logic [evad_pkg::SUM_W-1:0]            sum_nxt;
	logic [evad_pkg::CNT_W-1:0]            cnt_nxt;

	assign rdy3  = !fv_s3 || frm_ready;
	assign take2 = v_s2 && (!fe_s2 || rdy3);
	assign rdy2  = !v_s2 || take2;
	assign rdy1  = !v_s1 || rdy2;

	assign in_ready  = rdy1;
	assign frm_valid = fv_s3;
	assign frm       = frm_s3;

	assign sq_full = sample_s1 * sample_s1;
	assign cnt_ok  = cnt_q < evad_pkg::CNT_W'(evad_pkg::MAX_FRAME);
	assign sum_nxt = cnt_ok ? acc_q + evad_pkg::SUM_W'(sq_s2) : acc_q;
	assign cnt_nxt = cnt_ok ? cnt_q + evad_pkg::CNT_W'(1) : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			fv_s3 <= 1'b0;
			acc_q <= '0;
			cnt_q <= '0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				fv_s3 <= take2 && fe_s2;
			end
			if (take2) begin
				if (fe_s2) begin
					acc_q <= '0;
					cnt_q <= '0;
				end else begin
					acc_q <= sum_nxt;
					cnt_q <= cnt_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			sample_s1 <= sample;
			fe_s1     <= frame_end;
		end
		if (rdy2 && v_s1) begin
			sq_s2 <= sq_full[evad_pkg::SQ_W-1:0];
			fe_s2 <= fe_s1;
		end
		if (take2 && fe_s2) begin
			frm_s3.sum <= sum_nxt;
			frm_s3.cnt <= cnt_nxt;
		end
	end

endmodule

// ===== design/evad_decide.sv =====
// ----------------------------------------------------------------------------
// Frame speech decision
// Compares frame energy against count times the threshold factor.
// ----------------------------------------------------------------------------
module evad_decide (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                frm_valid,
	output logic                                frm_ready,
	input  evad_pkg::frame_t                    frm,
	input  logic signed [evad_pkg::THR_W-1:0]   threshold,
	input  logic [evad_pkg::K_W-1:0]            k,
	output logic                                dec_valid,
	input  logic                                dec_ready,
	output logic                                speech
);

	logic                                          v_s4;
	logic [evad_pkg::SUM_W-1:0]                    sum_s4;
	logic                                          low_s4;
	logic [evad_pkg::CNT_W+evad_pkg::KHI_W-1:0]    ph_s4;
	logic [evad_pkg::CNT_W+evad_pkg::KLO_W-1:0]    pl_s4;
	logic                                          v_s5;
	logic                                          speech_s5;

	logic                                          rdy4;
	logic                                          rdy5;
	logic [evad_pkg::CMP_W-1:0]                    lhs;
	logic [evad_pkg::CMP_W-1:0]                    rhs;
	logic                                          above;
	logic                                          below;
	logic                                          dec;

	assign rdy5      = !v_s5 || dec_ready;
	assign rdy4      = !v_s4 || rdy5;
	assign frm_ready = rdy4;
	assign dec_valid = v_s5;
	assign speech    = speech_s5;

	assign lhs   = evad_pkg::CMP_W'({sum_s4, {evad_pkg::K_FRAC{1'b0}}});
	assign rhs   = evad_pkg::CMP_W'({ph_s4, {evad_pkg::KLO_W{1'b0}}})
		+ evad_pkg::CMP_W'(pl_s4);
	assign above = threshold > evad_pkg::THR_W'(0);
	assign below = threshold < evad_pkg::THR_MIN;

	always_comb begin
		if (below) begin
			dec = 1'b1;
		end else if (above || low_s4) begin
			dec = 1'b0;
		end else begin
			dec = lhs > rhs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy4) begin
				v_s4 <= frm_valid;
			end
			if (rdy5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && frm_valid) begin
			sum_s4 <= frm.sum;
			low_s4 <= (frm.cnt == '0) || (frm.sum < evad_pkg::SUM_W'(frm.cnt));
			ph_s4  <= frm.cnt * k[evad_pkg::K_W-1:evad_pkg::KLO_W];
			pl_s4  <= frm.cnt * k[evad_pkg::KLO_W-1:0];
		end
		if (rdy5 && v_s4) begin
			speech_s5 <= dec;
		end
	end

endmodule

// ===== design/energy_voice_activity_detector_unit.sv =====
// ----------------------------------------------------------------------------
// Energy voice activity detector
// Judges each audio frame by mean-square level and tracks speech state.
//
//   Channel   Signals                                   Moves
//   input     in_valid/in_ready, sample, frame_end      one sample request
//   output    out_valid/out_ready, vad_result           one result per frame
//   config    psel/penable/pwrite/paddr/pwdata/prdata   register access
//
// One sample is taken every clock cycle while in_ready is high; the squarer
// and accumulator run at full rate. The result of a frame passes, after its
// frame-end sample is taken, through input, square, frame, multiply, compare
// and output registers. Reset clears all control state at once.
// The input stalls only while a result waits in the output register.
// ----------------------------------------------------------------------------
`include "energy_voice_activity_detector_unit_macros.svh"

module energy_voice_activity_detector_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [evad_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 frame_end,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           vad_result,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [evad_pkg::ADDR_W-1:0]          paddr,
	input  logic [evad_pkg::DATA_W-1:0]          pwdata,
	output logic [evad_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready
);

	logic signed [evad_pkg::THR_W-1:0] threshold_q;
	logic [evad_pkg::K_W-1:0]          k_q;
	logic [evad_pkg::TIME_W-1:0]       min_speech_q;
	logic [evad_pkg::TIME_W-1:0]       min_silence_q;
	logic [evad_pkg::FMS_W-1:0]        frame_ms_q;
	logic [evad_pkg::TIME_W-1:0]       speech_time_q;
	logic [evad_pkg::TIME_W-1:0]       silence_time_q;
	logic                              in_speech_q;
	logic                              out_valid_q;
	logic [1:0]                        vad_result_q;

	logic                              wr_en;
	logic [1:0]                        reg_idx;
	logic [evad_pkg::THR_W-1:0]        thr_neg;
	logic                              frm_valid;
	logic                              frm_ready;
	evad_pkg::frame_t                  frm;
	logic                              dec_valid;
	logic                              dec_ready;
	logic                              speech;
	logic                              load;
	logic [evad_pkg::TIME_W:0]         speech_add;
	logic [evad_pkg::TIME_W:0]         silence_add;
	logic [evad_pkg::TIME_W-1:0]       speech_sat;
	logic [evad_pkg::TIME_W-1:0]       silence_sat;

	evad_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.frame_end (frame_end),
		.frm_valid (frm_valid),
		.frm_ready (frm_ready),
		.frm       (frm)
	);

	evad_decide u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.frm_valid (frm_valid),
		.frm_ready (frm_ready),
		.frm       (frm),
		.threshold (threshold_q),
		.k         (k_q),
		.dec_valid (dec_valid),
		.dec_ready (dec_ready),
		.speech    (speech)
	);

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];
	assign thr_neg = -pwdata[evad_pkg::THR_W-1:0];

	always_comb begin
		unique case (reg_idx)
			evad_pkg::REG_THRESHOLD: begin
				prdata = {{(evad_pkg::DATA_W-evad_pkg::THR_W){threshold_q[evad_pkg::THR_W-1]}},
					threshold_q};
			end
			evad_pkg::REG_MIN_SPEECH: begin
				prdata = evad_pkg::DATA_W'(min_speech_q);
			end
			evad_pkg::REG_MIN_SILENCE: begin
				prdata = evad_pkg::DATA_W'(min_silence_q);
			end
			evad_pkg::REG_FRAME_MS: begin
				prdata = evad_pkg::DATA_W'(frame_ms_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= evad_pkg::THR_RESET;
			k_q           <= evad_pkg::KTAB[evad_pkg::THR_RESET_N];
			min_speech_q  <= evad_pkg::MIN_SPEECH_RST;
			min_silence_q <= evad_pkg::MIN_SILENCE_RST;
			frame_ms_q    <= evad_pkg::FRAME_MS_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				evad_pkg::REG_THRESHOLD: begin
					threshold_q <= pwdata[evad_pkg::THR_W-1:0];
					if (thr_neg <= evad_pkg::THR_W'(evad_pkg::THR_SPAN)) begin
						k_q <= evad_pkg::KTAB[thr_neg[6:0]];
					end
				end
				evad_pkg::REG_MIN_SPEECH: begin
					min_speech_q <= pwdata[evad_pkg::TIME_W-1:0];
				end
				evad_pkg::REG_MIN_SILENCE: begin
					min_silence_q <= pwdata[evad_pkg::TIME_W-1:0];
				end
				evad_pkg::REG_FRAME_MS: begin
					frame_ms_q <= pwdata[evad_pkg::FMS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign dec_ready   = !out_valid_q || out_ready;
	assign load        = dec_valid && dec_ready;
	assign speech_add  = {1'b0, speech_time_q} + (evad_pkg::TIME_W + 1)'(frame_ms_q);
	assign silence_add = {1'b0, silence_time_q} + (evad_pkg::TIME_W + 1)'(frame_ms_q);
	assign speech_sat  = speech_add[evad_pkg::TIME_W] ? '1 : speech_add[evad_pkg::TIME_W-1:0];
	assign silence_sat = silence_add[evad_pkg::TIME_W] ? '1 : silence_add[evad_pkg::TIME_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speech_time_q  <= '0;
			silence_time_q <= '0;
			in_speech_q    <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (dec_ready) begin
				out_valid_q <= dec_valid;
			end
			if (load) begin
				if (speech) begin
					silence_time_q <= '0;
					speech_time_q  <= speech_sat;
					if (!in_speech_q && speech_sat >= min_speech_q) begin
						in_speech_q <= 1'b1;
					end
				end else begin
					speech_time_q  <= '0;
					silence_time_q <= silence_sat;
					if (in_speech_q && silence_sat >= min_silence_q) begin
						in_speech_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (speech) begin
				vad_result_q <= (in_speech_q || speech_sat >= min_speech_q) ?
					evad_pkg::RES_SPEECH : evad_pkg::RES_SILENCE;
			end else if (in_speech_q && silence_sat >= min_silence_q) begin
				vad_result_q <= evad_pkg::RES_END;
			end else begin
				vad_result_q <= in_speech_q ? evad_pkg::RES_SPEECH : evad_pkg::RES_SILENCE;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign vad_result = vad_result_q;

	`EVAD_NEVER(a_times_exclusive, (speech_time_q != '0) && (silence_time_q != '0), "speech and silence times both running")
	`EVAD_ASSERT(a_result_state, out_valid_q |-> ((vad_result_q == evad_pkg::RES_SPEECH) == in_speech_q), "result disagrees with speech state")
	`EVAD_ASSERT(a_stall_cause, !in_ready |-> (out_valid_q && !out_ready), "input stalled without a waiting result")

endmodule
